FILE: rtl/ffha_pkg.sv
package ffha_pkg;

	localparam int unsigned MaxBlocksDef = 64;
	localparam int unsigned HeaderBytesDef = 48;
	localparam logic [15:0] HeapReset = 16'd50000;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NO_FIT    = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t        command;
		logic [15:0] request_bytes;
		logic [15:0] free_address;
	} in_t;

	typedef struct packed {
		logic [15:0] block_address;
		status_t     status;
		logic [1:0]  blocks_merged;
	} out_t;

	// One table entry: header offset, payload size, allocated flag.
	typedef struct packed {
		logic [15:0] offset;
		logic [15:0] size;
		logic        in_use;
	} ent_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_NRD,
		S_NCAP,
		S_MRG1,
		S_MRG2,
		S_MOVE,
		S_WR1,
		S_WR2,
		S_FIN
	} fsm_t;

endpackage

FILE: rtl/first_fit_heap_allocator_unit.sv
// First-fit heap allocator with coalescing.
// The block keeps an address-ordered table of heap blocks in a single-port-write,
// registered-read RAM. Each input word carries a command: allocate rounds the
// request up to a multiple of four and takes the lowest free block whose payload
// exceeds the request plus one header, splitting it; free finds an allocated
// block by payload offset, releases it and merges it with free neighbors.
// Input and output channels use valid and stall; a word moves on a clock edge
// with valid high and stall low. The configuration channel (valid/ready) writes
// the heap size and rebuilds the table as one free block.
// One word is handled at a time. The table scan reads one entry per cycle
// through the RAM read port, and a split or merge then moves the following
// entries one per cycle through the same port. After reset the sequencer
// writes the first table entry before it accepts a word. If the receiver
// stalls, the finished result waits in the output register; the block
// accepts and works on the next word, and only holds its own finish step
// until the output register is free.
module first_fit_heap_allocator_unit import ffha_pkg::*; #(
	parameter int unsigned MAX_BLOCKS   = MaxBlocksDef,
	parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int unsigned IW = $clog2(MAX_BLOCKS);
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned EW = $bits(ent_t);
	localparam logic [15:0] HDR = 16'(HEADER_BYTES);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
	localparam logic [CW-1:0] ONE = CW'(1);

	fsm_t state_q, state_d;

	logic [15:0]   heap_q;
	logic [CW-1:0] cnt_q;
	cmd_t          cmd_q;
	logic [16:0]   amt_q;
	logic [17:0]   need_q;
	logic [15:0]   addr_q;
	logic [CW-1:0] ra_q, chk_q, f_q, rj_q, end_q, wa_q, p_q;
	logic          chk_v_q, up_q, iss_q, wv_q, nm_q;
	logic [1:0]    r_q;
	ent_t          ent_q, prev_q, nxt_q;
	logic [15:0]   size1_q;
	out_t          res_q, out_q;
	logic          out_valid_q;

	// RAM port
	logic            we;
	logic [IW-1:0]   waddr, raddr;
	ent_t            wdata, rdata;
	logic [EW-1:0]   rdata_raw;

	ffha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);
	assign rdata = ent_t'(rdata_raw);

	// Comparison of the entry just read against the request.
	logic        match;
	logic        issue;
	logic        last_chk;
	logic        nm, pm;
	logic [15:0] size2;
	logic [CW-1:0] p_d, start_dn;
	logic [1:0]  r_d;
	logic        res_ld;
	out_t        res_d;
	logic        move_done;
	logic        fin_go;

	always_comb begin
		if (cmd_q == CMD_ALLOC) begin
			match = !rdata.in_use && ({2'b00, rdata.size} > need_q);
		end else begin
			match = rdata.in_use && (({1'b0, rdata.offset} + {1'b0, HDR}) == {1'b0, addr_q});
		end
	end

	assign issue    = ra_q < cnt_q;
	assign last_chk = (chk_q + ONE) == cnt_q;
	assign nm       = ((f_q + ONE) < cnt_q) && !nxt_q.in_use;
	assign pm       = (f_q != '0) && !prev_q.in_use;
	assign size2    = pm ? (prev_q.size + HDR + size1_q) : size1_q;
	assign p_d      = pm ? (f_q - ONE) : f_q;
	assign r_d      = {1'b0, nm_q} + {1'b0, pm};
	assign start_dn = p_d + ONE + CW'(r_d);
	assign move_done = !iss_q && !wv_q;
	assign fin_go   = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = '0;
		wdata   = '0;
		raddr   = '0;
		res_ld  = 1'b0;
		res_d   = '0;
		unique case (state_q)
			S_INIT: begin
				we          = 1'b1;
				wdata.offset = '0;
				wdata.size  = (heap_q >= HDR) ? (heap_q - HDR) : '0;
				state_d     = S_IDLE;
			end
			S_IDLE: begin
				if (cfg_valid) begin
					state_d = S_INIT;
				end else if (in_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				raddr = ra_q[IW-1:0];
				if (chk_v_q && match) begin
					if (cmd_q == CMD_ALLOC) begin
						if (cnt_q == MAXC) begin
							res_ld       = 1'b1;
							res_d.status = STS_FULL;
							state_d      = S_FIN;
						end else if (last_chk) begin
							state_d = S_WR1;
						end else begin
							state_d = S_MOVE;
						end
					end else begin
						state_d = last_chk ? S_MRG1 : S_NRD;
					end
				end else if (chk_v_q && last_chk) begin
					res_ld       = 1'b1;
					res_d.status = (cmd_q == CMD_ALLOC) ? STS_NO_FIT : STS_NOT_FOUND;
					state_d      = S_FIN;
				end
			end
			S_NRD: begin
				raddr   = f_q[IW-1:0] + IW'(1);
				state_d = S_NCAP;
			end
			S_NCAP: begin
				state_d = S_MRG1;
			end
			S_MRG1: begin
				state_d = S_MRG2;
			end
			S_MRG2: begin
				we           = 1'b1;
				waddr        = p_d[IW-1:0];
				wdata.offset = pm ? prev_q.offset : ent_q.offset;
				wdata.size   = size2;
				wdata.in_use = 1'b0;
				res_ld              = 1'b1;
				res_d.status        = STS_OK;
				res_d.blocks_merged = r_d;
				state_d = (r_d == 2'd0 || start_dn >= cnt_q) ? S_FIN : S_MOVE;
			end
			S_MOVE: begin
				raddr = rj_q[IW-1:0];
				we    = wv_q;
				waddr = wa_q[IW-1:0];
				wdata = rdata;
				if (move_done) begin
					state_d = up_q ? S_WR1 : S_FIN;
				end
			end
			S_WR1: begin
				we           = 1'b1;
				waddr        = f_q[IW-1:0] + IW'(1);
				wdata.offset = ent_q.offset + HDR + amt_q[15:0];
				wdata.size   = ent_q.size - HDR - amt_q[15:0];
				wdata.in_use = 1'b0;
				state_d      = S_WR2;
			end
			S_WR2: begin
				we           = 1'b1;
				waddr        = f_q[IW-1:0];
				wdata.offset = ent_q.offset;
				wdata.size   = amt_q[15:0];
				wdata.in_use = 1'b1;
				res_ld              = 1'b1;
				res_d.status        = STS_OK;
				res_d.block_address = ent_q.offset + HDR;
				state_d      = S_FIN;
			end
			S_FIN: begin
				if (fin_go) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers of the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q      <= HeapReset;
			cnt_q       <= ONE;
			chk_v_q     <= 1'b0;
			iss_q       <= 1'b0;
			wv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result enters the output register as the old one leaves or
			// once it has left.
			if (state_q == S_FIN && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					cnt_q <= ONE;
				end
				S_IDLE: begin
					if (cfg_valid) begin
						heap_q <= cfg_data;
					end
					chk_v_q <= 1'b0;
				end
				S_SCAN: begin
					chk_v_q <= issue;
					if (chk_v_q && match && cmd_q == CMD_ALLOC) begin
						iss_q <= 1'b1;
						wv_q  <= 1'b0;
					end
				end
				S_MRG2: begin
					iss_q <= 1'b1;
					wv_q  <= 1'b0;
					if (r_d == 2'd0 || start_dn >= cnt_q) begin
						cnt_q <= cnt_q - CW'(r_d);
					end
				end
				S_MOVE: begin
					wv_q <= iss_q;
					if (iss_q && rj_q == end_q) begin
						iss_q <= 1'b0;
					end
					if (move_done && !up_q) begin
						cnt_q <= cnt_q - CW'(r_q);
					end
				end
				S_WR2: begin
					cnt_q <= cnt_q + ONE;
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_q <= res_d;
		end
		if (state_q == S_FIN && fin_go) begin
			out_q <= res_q;
		end
		unique case (state_q)
			S_IDLE: begin
				cmd_q  <= in_data.command;
				addr_q <= in_data.free_address;
				amt_q  <= ({1'b0, in_data.request_bytes} + 17'd3) & ~17'd3;
				need_q <= (({2'b00, in_data.request_bytes} + 18'd3) & ~18'd3) + {2'b00, HDR};
				ra_q   <= '0;
			end
			S_SCAN: begin
				if (issue) begin
					ra_q <= ra_q + ONE;
				end
				chk_q <= ra_q;
				if (chk_v_q) begin
					if (match) begin
						f_q   <= chk_q;
						ent_q <= rdata;
					end else begin
						prev_q <= rdata;
					end
				end
				rj_q  <= cnt_q - ONE;
				end_q <= chk_q + ONE;
				up_q  <= 1'b1;
			end
			S_NCAP: begin
				nxt_q <= rdata;
			end
			S_MRG1: begin
				nm_q    <= nm;
				size1_q <= nm ? (ent_q.size + HDR + nxt_q.size) : ent_q.size;
			end
			S_MRG2: begin
				r_q   <= r_d;
				p_q   <= p_d;
				rj_q  <= start_dn;
				end_q <= cnt_q - ONE;
				up_q  <= 1'b0;
			end
			S_MOVE: begin
				wa_q <= up_q ? (rj_q + ONE) : (rj_q - CW'(r_q));
				if (iss_q && rj_q != end_q) begin
					rj_q <= up_q ? (rj_q - ONE) : (rj_q + ONE);
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != S_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 && cnt_q <= MAXC)
		else $error("table entry count out of range");

	a_cfg_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && cfg_valid) |=> state_q == S_INIT)
		else $error("configuration write did not rebuild the table");

	a_move_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE && wv_q) |-> wa_q < MAXC)
		else $error("entry move writes beyond the table");

	a_merge_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE && !up_q) |-> (p_q < cnt_q && r_q != 2'd0))
		else $error("compaction without a merge");

endmodule

FILE: rtl/ffha_ram.sv
module ffha_ram import ffha_pkg::*; #(
	parameter int unsigned WIDTH = 33,
	parameter int unsigned DEPTH = MaxBlocksDef
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
